// ----- design/drt_pkg.sv -----
// types, constants and rectangle functions shared by the dirty rectangle tracker
// no dependencies; used by drt_cell, drt_ctrl and dirty_rectangle_tracker_unit
package drt_pkg;

   localparam int DEFAULT_CAPACITY = 8;
   localparam int COORD_W = 16;
   localparam int LIMIT_W = 4;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   localparam logic ACT_INVALIDATE = 1'b0;
   localparam logic ACT_TAKE = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] h;
      logic [COORD_W-1:0] w;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } rect_type;

   typedef struct packed {
      logic live;
      logic pend;
      logic forced;
      logic added;
      rect_type rect;
   } token_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAKE
   } state_type;

   // right or bottom edge wrapped to 16 bits, compared with other edge minus one
   function automatic logic rect_near(rect_type a, rect_type b);
      logic [15:0] ar;
      logic [15:0] ab;
      logic [15:0] br;
      logic [15:0] bb;
      logic signed [16:0] axm;
      logic signed [16:0] aym;
      logic signed [16:0] bxm;
      logic signed [16:0] bym;
      logic far_x;
      logic far_y;
      ar = a.x + a.w;
      ab = a.y + a.h;
      br = b.x + b.w;
      bb = b.y + b.h;
      axm = $signed({a.x[15], a.x}) - 17'sd1;
      aym = $signed({a.y[15], a.y}) - 17'sd1;
      bxm = $signed({b.x[15], b.x}) - 17'sd1;
      bym = $signed({b.y[15], b.y}) - 17'sd1;
      far_x = ($signed({ar[15], ar}) < bxm) || ($signed({br[15], br}) < axm);
      far_y = ($signed({ab[15], ab}) < bym) || ($signed({bb[15], bb}) < aym);
      return !(far_x || far_y);
   endfunction

   // bounding box of two rectangles
   function automatic rect_type rect_merge(rect_type d, rect_type s);
      rect_type r;
      logic signed [17:0] dr;
      logic signed [17:0] sr;
      logic signed [17:0] db;
      logic signed [17:0] sb;
      logic [15:0] x2;
      logic [15:0] y2;
      r.x = ($signed(d.x) < $signed(s.x)) ? d.x : s.x;
      r.y = ($signed(d.y) < $signed(s.y)) ? d.y : s.y;
      dr = $signed({{2{d.x[15]}}, d.x}) + $signed({2'b00, d.w});
      sr = $signed({{2{s.x[15]}}, s.x}) + $signed({2'b00, s.w});
      db = $signed({{2{d.y[15]}}, d.y}) + $signed({2'b00, d.h});
      sb = $signed({{2{s.y[15]}}, s.y}) + $signed({2'b00, s.h});
      x2 = (dr > sr) ? dr[15:0] : sr[15:0];
      y2 = (db > sb) ? db[15:0] : sb[15:0];
      r.w = x2 - r.x;
      r.h = y2 - r.y;
      return r;
   endfunction

endpackage

// ----- design/drt_cell.sv -----
// one list entry of the dirty rectangle tracker, with its stage of the search token
// depends on drt_pkg
module drt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  drt_pkg::token_type     tok_i,
   output drt_pkg::token_type     tok_o,
   input  drt_pkg::rect_type      nbr_rect_i,
   input  logic                   nbr_valid_i,
   input  drt_pkg::cell_ctrl_type ctl_i,
   output drt_pkg::rect_type      entry_o,
   output logic                   valid_o
);
   import drt_pkg::*;

   rect_type  entry_ff, entry_in;
   logic      valid_ff, valid_in;
   token_type tok_ff, tok_in;
   logic      active;
   logic      hit;
   logic      app;

   assign active = tok_i.live && tok_i.pend;
   assign hit = active && valid_ff && (tok_i.forced || rect_near(entry_ff, tok_i.rect));
   assign app = active && !valid_ff && !tok_i.forced;

   always_comb begin
      entry_in = entry_ff;
      if (ctl_i.shift) begin
         entry_in = nbr_rect_i;
      end else if (hit) begin
         entry_in = rect_merge(entry_ff, tok_i.rect);
      end else if (app) begin
         entry_in = tok_i.rect;
      end

      valid_in = valid_ff;
      if (ctl_i.clear) begin
         valid_in = 1'b0;
      end else if (ctl_i.shift) begin
         valid_in = nbr_valid_i;
      end else if (app) begin
         valid_in = 1'b1;
      end

      tok_in = tok_i;
      tok_in.live = tok_i.live && !tok_i.forced;
      tok_in.pend = tok_i.pend && !hit && !app;
      tok_in.forced = 1'b0;
      tok_in.added = tok_i.added || app;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign tok_o = tok_ff;
   assign entry_o = entry_ff;
   assign valid_o = valid_ff;

endmodule

// ----- design/drt_ctrl.sv -----
// sequencer of the dirty rectangle tracker: request decode, token launch, take and result register
// depends on drt_pkg
module drt_ctrl #(
   parameter int CAPACITY = drt_pkg::DEFAULT_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [drt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [drt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   output drt_pkg::token_type              tok_o,
   input  drt_pkg::token_type              tail_i,
   input  drt_pkg::rect_type               head_i,
   output drt_pkg::cell_ctrl_type          ctl_o
);
   import drt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int NW = (CW > LIMIT_W) ? CW : LIMIT_W;

   state_type               state_ff, state_in;
   token_type               tok_ff, tok_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [NW-1:0]           n_ff, n_in;
   logic [NW-1:0]           k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    accept;
   logic                    out_free;
   logic                    last_load;
   logic [NW-1:0]           lim;
   rect_type                req_rect;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_rect = req_tdata[4*COORD_W-1:0];
   assign lim = (NW'(req_tdata[4*COORD_W +: LIMIT_W]) > NW'(CAPACITY)) ?
                NW'(CAPACITY) : NW'(req_tdata[4*COORD_W +: LIMIT_W]);
   assign last_load = (n_ff != '0) && (k_ff == n_ff - NW'(1));

   always_comb begin
      state_in = state_ff;
      tok_in = tok_ff;
      tok_in.live = 1'b0;
      tok_o = tok_ff;
      count_in = count_ff;
      n_in = n_ff;
      k_in = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      ctl_o = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == ACT_INVALIDATE) begin
                  tok_in.live = 1'b1;
                  tok_in.pend = 1'b1;
                  tok_in.forced = 1'b0;
                  tok_in.added = 1'b0;
                  tok_in.rect = req_rect;
                  state_in = ST_SCAN;
               end else begin
                  n_in = (NW'(count_ff) > lim) ? lim : NW'(count_ff);
                  k_in = '0;
                  state_in = ST_TAKE;
               end
            end
         end
         ST_SCAN: begin
            if (tail_i.live) begin
               // list full and nothing matched: fold into entry 0
               if (tail_i.pend) begin
                  tok_o.live = 1'b1;
                  tok_o.pend = 1'b1;
                  tok_o.forced = 1'b1;
                  tok_o.added = 1'b0;
                  tok_o.rect = tail_i.rect;
               end
               if (tail_i.added) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_TAKE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (n_ff == '0) begin
                  rsp_data_in = '0;
                  rsp_user_in = 1'b1;
                  rsp_last_in = 1'b1;
                  ctl_o.clear = 1'b1;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  rsp_data_in = '0;
                  rsp_data_in[4*COORD_W-1:0] = head_i;
                  rsp_data_in[4*COORD_W +: LIMIT_W] = n_ff[LIMIT_W-1:0];
                  rsp_user_in = 1'b0;
                  rsp_last_in = last_load;
                  ctl_o.shift = 1'b1;
                  k_in = k_ff + NW'(1);
                  if (last_load) begin
                     ctl_o.clear = 1'b1;
                     count_in = '0;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tok_ff <= '0;
         count_ff <= '0;
         n_ff <= '0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tok_ff <= tok_in;
         count_ff <= count_in;
         n_ff <= n_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail_i.live |-> state_ff == ST_SCAN)
      else $error("search token left the chain outside a scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_launch: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == ACT_INVALIDATE) |=> tok_ff.live && tok_ff.pend)
      else $error("invalidate did not launch a search token");

   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAKE && out_free && (n_ff == '0 || last_load)) |=>
      count_ff == '0 && state_ff == ST_IDLE && rsp_tlast)
      else $error("take did not end with a cleared list");

endmodule

// ----- design/dirty_rectangle_tracker_unit.sv -----
// Dirty rectangle tracker: a chain of CAPACITY entry cells holds the list. An invalidate
// sends a search token down the chain, one cell per cycle; the first valid cell that
// overlaps or touches the rectangle grows to cover it, otherwise the first empty cell
// stores it, and on a full list with no match entry 0 absorbs it after the token leaves
// the chain. An invalidate holds req_tready low until the token leaves the chain,
// whether it merges, appends or folds into entry 0. A take shifts the list toward cell 0
// and returns one rectangle per cycle as the result register drains, then clears the
// list; it holds req_tready low until the last result is loaded, also for the single
// empty-flagged result when nothing is returned. The result register lets a new request
// be accepted while the final result still waits.
// depends on drt_pkg, drt_cell and drt_ctrl
module dirty_rectangle_tracker_unit #(
   parameter int CAPACITY = drt_pkg::DEFAULT_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rect_x, rect_y, rect_width, rect_height, take_limit, zero pad
   input  logic [drt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_x, out_y, out_width, out_height, taken_count, zero pad
   output logic [drt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // is_empty
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import drt_pkg::*;

   token_type     tok   [CAPACITY+1];
   rect_type      ent   [CAPACITY];
   logic          val   [CAPACITY];
   cell_ctrl_type ctl;

   drt_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .tok_o      (tok[0]),
      .tail_i     (tok[CAPACITY]),
      .head_i     (ent[0]),
      .ctl_o      (ctl)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      rect_type nbr_rect;
      logic     nbr_valid;
      if (i < CAPACITY - 1) begin : g_mid
         assign nbr_rect = ent[i+1];
         assign nbr_valid = val[i+1];
      end else begin : g_end
         assign nbr_rect = '0;
         assign nbr_valid = 1'b0;
      end
      drt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .tok_i       (tok[i]),
         .tok_o       (tok[i+1]),
         .nbr_rect_i  (nbr_rect),
         .nbr_valid_i (nbr_valid),
         .ctl_i       (ctl),
         .entry_o     (ent[i]),
         .valid_o     (val[i])
      );
   end

endmodule
